[rtl/pts_pkg.sv]
`timescale 1ns / 1ps

package pts_pkg;

  // Fixed widths of the item fields.
  localparam int TASK_IDX_W = 4;
  localparam int PRIO_REQ_W = 8;
  localparam int CNT_W      = 9;

  // Time counters saturate at this value on a refill.
  localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

  // Parameter defaults for the top level.
  localparam int NUM_TASKS_DEF     = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  // Command codes of an input item.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;          // capture the accepted input item
    logic load_wr;      // write priority and runnable flag, clear counter
    logic tick_wr;      // decrement the current task's counter
    logic scan_start;   // start a pass over tasks 1 to N-1
    logic scan_refill;  // the pass also refills every counter
    logic commit;       // make the best candidate the current task
    logic set_nr;       // flag that no task was ready
    logic out_load;     // load the output register
  } pts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_load;   // the offered item is a load command
    logic sched_req;    // the tick in progress must schedule
    logic scan_done;    // the last task of a pass was evaluated
    logic best_found;   // the pass found an eligible task
  } pts_status_t;

endpackage

[rtl/priority_task_scheduler_unit.sv]
`timescale 1ns / 1ps

// Priority time-slice task scheduler. Each item is a timer tick or a load of
// one task's priority and runnable flag, and each item yields exactly one
// result: the current task, its remaining time slice, and flags for a task
// switch and for "no task ready". Items are handled one at a time. A load or
// a tick that does not schedule passes through its load or tick state to the
// result state. A tick that schedules adds a pass over tasks 1 to NUM_TASKS-1
// through the single read port of the task tables; if no task qualifies, a
// second pass refills the counters and rescans. A new item is accepted while
// a finished result still waits in the output register. After reset all
// tables read as their reset values at once; no clearing pass runs.
module priority_task_scheduler_unit import pts_pkg::*; #(
  parameter int NUM_TASKS     = NUM_TASKS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic [TASK_IDX_W-1:0] task_index_i,
  input  logic [PRIO_REQ_W-1:0] priority_req_i,
  input  logic                  running_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TASK_IDX_W-1:0] current_task_o,
  output logic                  switched_o,
  output logic                  no_ready_o,
  output logic [CNT_W-1:0]      current_counter_o
);

  pts_cmd_t    cmd;
  pts_status_t status;

  // Sequencer for one item.
  pts_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Task tables, scan unit and output register.
  pts_datapath #(
    .NUM_TASKS     (NUM_TASKS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .command_i         (command_i),
    .task_index_i      (task_index_i),
    .priority_req_i    (priority_req_i),
    .running_i         (running_i),
    .current_task_o    (current_task_o),
    .switched_o        (switched_o),
    .no_ready_o        (no_ready_o),
    .current_counter_o (current_counter_o)
  );

endmodule

[rtl/pts_datapath.sv]
`timescale 1ns / 1ps

module pts_datapath import pts_pkg::*; #(
  parameter int NUM_TASKS     = NUM_TASKS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pts_cmd_t              cmd_i,
  output pts_status_t           status_o,
  input  logic                  command_i,
  input  logic [TASK_IDX_W-1:0] task_index_i,
  input  logic [PRIO_REQ_W-1:0] priority_req_i,
  input  logic                  running_i,
  output logic [TASK_IDX_W-1:0] current_task_o,
  output logic                  switched_o,
  output logic                  no_ready_o,
  output logic [CNT_W-1:0]      current_counter_o
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int SUM_W = ((PRIORITY_BITS > CNT_W) ? PRIORITY_BITS : CNT_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  // Task tables: counters and priority with runnable flag, each with valid bits
  // so that an entry never written reads as its reset value.
  logic [CNT_W-1:0]           cnt_mem [NUM_TASKS];
  logic [PRIORITY_BITS:0]     pr_mem  [NUM_TASKS];
  logic [NUM_TASKS-1:0]       cnt_vld_q;
  logic [NUM_TASKS-1:0]       pr_vld_q;

  // Captured input item.
  logic [TASK_IDX_W-1:0]      idx_q;
  logic [PRIORITY_BITS-1:0]   prio_q;
  logic                       run_q;

  // Current task and a mirror of its counter.
  logic [IDX_W-1:0]           cur_q, cur_d;
  logic [CNT_W-1:0]           cur_cnt_q, cur_cnt_d;

  // Scan pipeline.
  logic                       iss_q;
  logic [IDX_W-1:0]           sc_q;
  logic                       refill_q;
  logic                       p_vld_q;
  logic [IDX_W-1:0]           p_idx_q;
  logic [CNT_W-1:0]           rd_cnt_q;
  logic                       rd_cnt_vld_q;
  logic [PRIORITY_BITS:0]     rd_pr_q;
  logic                       rd_pr_vld_q;

  // Best candidate of the pass.
  logic [IDX_W-1:0]           best_idx_q;
  logic [PRIORITY_BITS-1:0]   best_prio_q;
  logic [CNT_W-1:0]           best_cnt_q;

  // Result flags and output register.
  logic                       sw_q;
  logic                       nr_q;
  logic [TASK_IDX_W-1:0]      out_task_q;
  logic                       out_sw_q;
  logic                       out_nr_q;
  logic [CNT_W-1:0]           out_cnt_q;

  logic                       idx_ok;
  logic [IDX_W-1:0]           load_addr;
  logic [CNT_W-1:0]           dec_cnt;
  logic [PRIORITY_BITS-1:0]   e_prio;
  logic                       e_run;
  logic [CNT_W-1:0]           e_cnt_raw;
  logic [SUM_W-1:0]           e_sum;
  logic [CNT_W-1:0]           e_cnt;
  logic                       e_better;
  logic                       cnt_we;
  logic [IDX_W-1:0]           cnt_wa;
  logic [CNT_W-1:0]           cnt_wd;

  // Decode of the captured load and the decremented current counter.
  always_comb begin
    idx_ok    = (idx_q != '0) && (int'(idx_q) < NUM_TASKS);
    load_addr = IDX_W'(idx_q);
    dec_cnt   = (cur_cnt_q == '0) ? '0 : cur_cnt_q - CNT_W'(1);
  end

  // Evaluation of the entry read in the previous cycle, with optional refill.
  always_comb begin
    e_prio    = rd_pr_vld_q ? rd_pr_q[PRIORITY_BITS-1:0] : '0;
    e_run     = rd_pr_vld_q ? rd_pr_q[PRIORITY_BITS] : 1'b1;
    e_cnt_raw = rd_cnt_vld_q ? rd_cnt_q : '0;
    e_sum     = SUM_W'(e_cnt_raw >> 1) + SUM_W'(e_prio);
    if (!refill_q) begin
      e_cnt = e_cnt_raw;
    end else if (e_sum > SUM_W'(CNT_MAX)) begin
      e_cnt = CNT_MAX;
    end else begin
      e_cnt = CNT_W'(e_sum);
    end
    e_better = e_run && (e_cnt != '0) &&
               ((best_idx_q == '0) || (e_prio > best_prio_q) ||
                ((e_prio == best_prio_q) && (e_cnt < best_cnt_q)));
  end

  // Single write port of the counter table.
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = load_addr;
    cnt_wd = '0;
    if (cmd_i.load_wr) begin
      cnt_we = idx_ok;
    end else if (cmd_i.tick_wr) begin
      cnt_we = (cur_q != '0);
      cnt_wa = cur_q;
      cnt_wd = dec_cnt;
    end else if (p_vld_q && refill_q) begin
      cnt_we = 1'b1;
      cnt_wa = p_idx_q;
      cnt_wd = e_cnt;
    end
  end

  // Next current task and its counter.
  always_comb begin
    cur_d     = cur_q;
    cur_cnt_d = cur_cnt_q;
    if (cmd_i.load_wr) begin
      if (idx_ok && (load_addr == cur_q)) begin
        cur_cnt_d = '0;
      end
    end else if (cmd_i.tick_wr) begin
      if (cur_q != '0) begin
        cur_cnt_d = dec_cnt;
      end
    end else if (cmd_i.commit) begin
      cur_d     = best_idx_q;
      cur_cnt_d = best_cnt_q;
    end else if (p_vld_q && refill_q && (p_idx_q == cur_q)) begin
      cur_cnt_d = e_cnt;
    end
  end

  // Table storage.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.load_wr && idx_ok) begin
      pr_mem[load_addr] <= {run_q, prio_q};
    end
    if (iss_q) begin
      rd_cnt_q <= cnt_mem[sc_q];
      rd_pr_q  <= pr_mem[sc_q];
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q    <= '0;
      pr_vld_q     <= '0;
      cur_q        <= '0;
      cur_cnt_q    <= '0;
      iss_q        <= 1'b0;
      sc_q         <= '0;
      refill_q     <= 1'b0;
      p_vld_q      <= 1'b0;
      p_idx_q      <= '0;
      rd_cnt_vld_q <= 1'b0;
      rd_pr_vld_q  <= 1'b0;
      best_idx_q   <= '0;
      sw_q         <= 1'b0;
      nr_q         <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      cur_cnt_q <= cur_cnt_d;
      if (cnt_we) begin
        cnt_vld_q[cnt_wa] <= 1'b1;
      end
      if (cmd_i.load_wr && idx_ok) begin
        pr_vld_q[load_addr] <= 1'b1;
      end
      // Read issue over tasks 1 to N-1.
      if (cmd_i.scan_start) begin
        iss_q    <= 1'b1;
        sc_q     <= IDX_W'(1);
        refill_q <= cmd_i.scan_refill;
      end else if (iss_q) begin
        if (sc_q == LAST_IDX) begin
          iss_q <= 1'b0;
        end else begin
          sc_q <= sc_q + IDX_W'(1);
        end
      end
      p_vld_q <= iss_q;
      if (iss_q) begin
        p_idx_q      <= sc_q;
        rd_cnt_vld_q <= cnt_vld_q[sc_q];
        rd_pr_vld_q  <= pr_vld_q[sc_q];
      end
      // Best candidate tracking.
      if (cmd_i.scan_start) begin
        best_idx_q <= '0;
      end else if (p_vld_q && e_better) begin
        best_idx_q <= p_idx_q;
      end
      // Result flags of the item in progress.
      if (cmd_i.cap) begin
        sw_q <= 1'b0;
        nr_q <= 1'b0;
      end else begin
        if (cmd_i.commit) begin
          sw_q <= (best_idx_q != cur_q);
        end
        if (cmd_i.set_nr) begin
          nr_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers: input capture, best candidate data and output.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      idx_q  <= task_index_i;
      prio_q <= PRIORITY_BITS'(priority_req_i);
      run_q  <= running_i;
    end
    if (p_vld_q && e_better) begin
      best_prio_q <= e_prio;
      best_cnt_q  <= e_cnt;
    end
    if (cmd_i.out_load) begin
      out_task_q <= TASK_IDX_W'(cur_q);
      out_sw_q   <= sw_q;
      out_nr_q   <= nr_q;
      out_cnt_q  <= cur_cnt_q;
    end
  end

  // Status and outputs.
  always_comb begin
    status_o.in_is_load = (command_i == CMD_LOAD);
    status_o.sched_req  = (cur_q == '0) || (cur_cnt_q <= CNT_W'(1));
    status_o.scan_done  = p_vld_q && (p_idx_q == LAST_IDX);
    status_o.best_found = (best_idx_q != '0);
    current_task_o      = out_task_q;
    switched_o          = out_sw_q;
    no_ready_o          = out_nr_q;
    current_counter_o   = out_cnt_q;
  end

  // The idle task's counter is never written.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (cnt_wa != '0))
    else $error("counter write to the idle task slot");

  // A commit hands over a real task, and the current task becomes it.
  a_commit_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (best_idx_q != '0))
    else $error("commit without an eligible task");

  a_commit_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (cur_q == $past(best_idx_q)))
    else $error("current task differs from the committed winner");

  // A pass ends cleanly: nothing is evaluated after its last task.
  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.scan_done |=> !p_vld_q)
    else $error("evaluation continued past the last task");

endmodule

[rtl/pts_controller.sv]
`timescale 1ns / 1ps

module pts_controller import pts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  pts_status_t status_i,
  output pts_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_TICK,
    S_SCAN,
    S_DECIDE,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   refilled_q, refilled_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Sequencing of one item and the output handshake.
  always_comb begin
    state_d     = state_q;
    refilled_d  = refilled_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    out_free    = !out_valid_q || out_ready_i;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap  = 1'b1;
          refilled_d = 1'b0;
          state_d    = status_i.in_is_load ? S_LOAD : S_TICK;
        end
      end
      S_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d       = S_RESULT;
      end
      S_TICK: begin
        cmd_o.tick_wr = 1'b1;
        if (status_i.sched_req) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SCAN: begin
        if (status_i.scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status_i.best_found) begin
          cmd_o.commit = 1'b1;
          state_d      = S_RESULT;
        end else if (!refilled_q) begin
          cmd_o.scan_start  = 1'b1;
          cmd_o.scan_refill = 1'b1;
          refilled_d        = 1'b1;
          state_d           = S_SCAN;
        end else begin
          cmd_o.set_nr = 1'b1;
          state_d      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      refilled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      refilled_q  <= refilled_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // The output register is only reloaded once the previous result has left.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // A refill pass happens at most once per item.
  a_one_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_refill |-> !refilled_q)
    else $error("second refill pass in one item");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import pts_pkg::*;

  localparam int NUM_TASKS     = NUM_TASKS_DEF;
  localparam int PRIORITY_BITS = PRIORITY_BITS_DEF;
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 60;
  localparam int STALL_LIMIT   = 4000;

  // One input item and one result item as they appear on the ports.
  typedef struct packed {
    logic                  command;
    logic [TASK_IDX_W-1:0] task_index;
    logic [PRIO_REQ_W-1:0] prio;
    logic                  running;
  } sched_item_t;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] task_id;
    logic                  switched;
    logic                  no_ready;
    logic [CNT_W-1:0]      slice;
  } sched_result_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_EVERY_FOURTH,
    RDY_MOSTLY
  } ready_mode_e;

  // Scoreboard: keeps its own copy of the task tables, predicts the result
  // of every accepted item, and checks results against the oldest prediction.
  class schedule_checker;
    logic [CNT_W-1:0]         slice_left[NUM_TASKS];
    logic [PRIORITY_BITS-1:0] prio_of[NUM_TASKS];
    logic                     is_runnable[NUM_TASKS];
    logic [TASK_IDX_W-1:0]    cur_task;
    sched_result_t            awaited_results[$];
    int unsigned              n_loads, n_ticks, n_switches, n_refills, n_no_ready;
    int unsigned              n_checked, n_errors;

    function new();
      for (int i = 0; i < NUM_TASKS; i++) begin
        slice_left[i]  = '0;
        prio_of[i]     = '0;
        is_runnable[i] = 1'b1;
      end
      cur_task   = '0;
      n_loads    = 0;
      n_ticks    = 0;
      n_switches = 0;
      n_refills  = 0;
      n_no_ready = 0;
      n_checked  = 0;
      n_errors   = 0;
    endfunction

    // Highest priority among runnable tasks with time left; ties go to the
    // smaller slice, then to the lower index. Zero means nobody qualifies.
    function int unsigned pick_next_task();
      int unsigned best;
      best = 0;
      for (int i = 1; i < NUM_TASKS; i++) begin
        if (is_runnable[i] && slice_left[i] != 0) begin
          if (best == 0 || prio_of[i] > prio_of[best] ||
              (prio_of[i] == prio_of[best] && slice_left[i] < slice_left[best])) begin
            best = i;
          end
        end
      end
      return best;
    endfunction

    // Every slice but the idle task's becomes half of itself plus the task's priority.
    function void refill_slices();
      int unsigned v;
      for (int i = 1; i < NUM_TASKS; i++) begin
        v = (int'(slice_left[i]) >> 1) + int'(prio_of[i]);
        slice_left[i] = (v > int'(CNT_MAX)) ? CNT_MAX : v[CNT_W-1:0];
      end
    endfunction

    // Apply one accepted item and queue the result it must produce.
    function void note_item(sched_item_t it);
      sched_result_t exp_res;
      int unsigned   next_task;
      logic          do_sched;
      exp_res = '0;
      if (it.command == CMD_LOAD) begin
        n_loads++;
        if (it.task_index != 0 && int'(it.task_index) < NUM_TASKS) begin
          prio_of[it.task_index]     = it.prio[PRIORITY_BITS-1:0];
          is_runnable[it.task_index] = it.running;
          slice_left[it.task_index]  = '0;
        end
      end else begin
        n_ticks++;
        do_sched = (cur_task == 0);
        if (!do_sched) begin
          if (slice_left[cur_task] != 0) slice_left[cur_task]--;
          do_sched = (slice_left[cur_task] == 0);
        end
        if (do_sched) begin
          next_task = pick_next_task();
          if (next_task == 0) begin
            n_refills++;
            refill_slices();
            next_task = pick_next_task();
          end
          if (next_task == 0) begin
            exp_res.no_ready = 1'b1;
            n_no_ready++;
          end else begin
            exp_res.switched = (next_task != cur_task);
            if (exp_res.switched) n_switches++;
            cur_task = next_task[TASK_IDX_W-1:0];
          end
        end
      end
      exp_res.task_id = cur_task;
      exp_res.slice   = slice_left[cur_task];
      awaited_results.push_back(exp_res);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(sched_result_t seen);
      sched_result_t exp_res;
      if (awaited_results.size() == 0) begin
        $error("result with no item outstanding: task %0d counter %0d",
               seen.task_id, seen.slice);
        n_errors++;
        return;
      end
      exp_res = awaited_results.pop_front();
      n_checked++;
      if (seen.task_id !== exp_res.task_id) begin
        $error("current_task: expected %0d, actual %0d", exp_res.task_id, seen.task_id);
        n_errors++;
      end
      if (seen.switched !== exp_res.switched) begin
        $error("switched: expected %0d, actual %0d", exp_res.switched, seen.switched);
        n_errors++;
      end
      if (seen.no_ready !== exp_res.no_ready) begin
        $error("no_ready: expected %0d, actual %0d", exp_res.no_ready, seen.no_ready);
        n_errors++;
      end
      if (seen.slice !== exp_res.slice) begin
        $error("current_counter: expected %0d, actual %0d", exp_res.slice, seen.slice);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction
  endclass

  logic                  clk_q          = 1'b0;
  logic                  rst_nq         = 1'b0;
  logic                  in_valid_q     = 1'b0;
  logic                  command_q      = CMD_TICK;
  logic [TASK_IDX_W-1:0] task_index_q   = '0;
  logic [PRIO_REQ_W-1:0] priority_req_q = '0;
  logic                  running_q      = 1'b0;
  logic                  out_ready_q    = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [TASK_IDX_W-1:0] current_task;
  logic                  switched;
  logic                  no_ready;
  logic [CNT_W-1:0]      current_counter;

  schedule_checker sb = new();
  bit              hold_req   = 1'b0;
  int unsigned     burst_left = 0;
  int unsigned     n_sent     = 0;

  priority_task_scheduler_unit #(
    .NUM_TASKS     (NUM_TASKS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) i_dut (
    .clk_i             (clk_q),
    .rst_ni            (rst_nq),
    .in_valid_i        (in_valid_q),
    .in_ready_o        (in_ready),
    .command_i         (command_q),
    .task_index_i      (task_index_q),
    .priority_req_i    (priority_req_q),
    .running_i         (running_q),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready_q),
    .current_task_o    (current_task),
    .switched_o        (switched),
    .no_ready_o        (no_ready),
    .current_counter_o (current_counter)
  );

  // Free-running clock.
  always #CLK_HALF clk_q = ~clk_q;

  // Check every result that the receiver accepts.
  always @(posedge clk_q) begin : result_monitor
    sched_result_t seen;
    if (rst_nq && out_valid && out_ready_q) begin
      seen.task_id  = current_task;
      seen.switched = switched;
      seen.no_ready = no_ready;
      seen.slice    = current_counter;
      sb.check_result(seen);
    end
  end

  // Receiver: stretches of different stall patterns, plus one long hold-off
  // on request so that the block backs up into its input.
  initial begin : receiver
    ready_mode_e mode;
    int unsigned stretch;
    int unsigned cyc;
    mode    = RDY_ALWAYS;
    stretch = 0;
    cyc     = 0;
    @(posedge clk_q);
    forever begin
      if (hold_req) begin
        out_ready_q <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_q);
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = ready_mode_e'($urandom_range(0, 3));
          stretch = $urandom_range(10, 120);
        end
        stretch--;
        cyc++;
        case (mode)
          RDY_ALWAYS:       out_ready_q <= 1'b1;
          RDY_COIN:         out_ready_q <= ($urandom_range(0, 1) == 1);
          RDY_EVERY_FOURTH: out_ready_q <= (cyc % 4 == 0);
          default:          out_ready_q <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk_q);
      end
    end
  end

  // Ends the run when neither side moves an item for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_q);
      if ((in_valid_q && in_ready) || (out_valid && out_ready_q)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic sched_item_t make_item(logic cmd, int unsigned idx,
                                            int unsigned prio, logic run);
    sched_item_t it;
    it.command    = cmd;
    it.task_index = idx[TASK_IDX_W-1:0];
    it.prio       = prio[PRIO_REQ_W-1:0];
    it.running    = run;
    return it;
  endfunction

  function automatic sched_item_t make_tick();
    return make_item(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)));
  endfunction

  // Mostly small priorities so that slices expire often; some full range
  // and some bit patterns at the extremes.
  function automatic int unsigned random_prio();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(0, 7);
    if (roll < 85) return $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      2:       return 8'hAA;
      default: return 8'h55;
    endcase
  endfunction

  function automatic sched_item_t random_item();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 58) return make_tick();
    if (roll < 95) return make_item(CMD_LOAD, $urandom_range(1, NUM_TASKS - 1), random_prio(),
                                    $urandom_range(0, 99) < 85);
    // Load to the idle slot, which the block ignores.
    return make_item(CMD_LOAD, 0, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input sched_item_t it);
    in_valid_q     <= 1'b1;
    command_q      <= it.command;
    task_index_q   <= it.task_index;
    priority_req_q <= it.prio;
    running_q      <= it.running;
    @(posedge clk_q);
    while (!in_ready) @(posedge clk_q);
    sb.note_item(it);
    if (!(it.command == CMD_LOAD && it.task_index == 0)) n_sent++;
  endtask

  task automatic idle_for(input int unsigned cycles);
    in_valid_q <= 1'b0;
    repeat (cycles) @(posedge clk_q);
  endtask

  // Send a list of items in bursts of random length with random gaps.
  task automatic send_items(input sched_item_t items[$]);
    foreach (items[k]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 15));
      end
      burst_left--;
      send_item(items[k]);
    end
  endtask

  // Stop offering items until every outstanding result has come back.
  task automatic drain();
    in_valid_q <= 1'b0;
    do @(posedge clk_q); while (sb.pending() != 0);
  endtask

  initial begin : stimulus
    sched_item_t plan[$];
    int unsigned roll;
    int unsigned k;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_q);
    rst_nq <= 1'b1;
    @(posedge clk_q);

    // Directed part: no task ready out of reset, ignored load to the idle
    // slot, extreme priorities, ties broken by index, reload of the current
    // task, expiry on a zero counter and the refill.
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_LOAD, 0, 255, 1'b1));
    plan.push_back(make_item(CMD_LOAD, 15, 255, 1'b1));
    plan.push_back(make_item(CMD_LOAD, 3, 2, 1'b1));
    plan.push_back(make_item(CMD_LOAD, 5, 2, 1'b1));
    plan.push_back(make_item(CMD_TICK, 15, 255, 1'b1));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_LOAD, 15, 1, 1'b0));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_LOAD, 7, 2, 1'b1));
    plan.push_back(make_item(CMD_LOAD, 9, 8'hAA, 1'b0));
    plan.push_back(make_item(CMD_LOAD, 10, 8'h55, 1'b1));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_LOAD, 10, 0, 1'b1));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    plan.push_back(make_item(CMD_TICK, 0, 0, 1'b0));
    send_items(plan);
    drain();

    // Random part, built from short sequences.
    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      plan.delete();
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        // Shut every task down so that scheduling finds nobody, then
        // bring a few back.
        for (int i = 1; i < NUM_TASKS; i++)
          plan.push_back(make_item(CMD_LOAD, i, random_prio(), 1'b0));
        repeat (3) plan.push_back(make_tick());
        k = $urandom_range(1, 3);
        repeat (k) plan.push_back(make_item(CMD_LOAD, $urandom_range(1, NUM_TASKS - 1),
                                            $urandom_range(1, 7), 1'b1));
      end else if (roll < 30) begin
        // A fresh set of tasks, then enough ticks to run through slices.
        k = $urandom_range(1, 6);
        repeat (k) plan.push_back(make_item(CMD_LOAD, $urandom_range(1, NUM_TASKS - 1),
                                            random_prio(), $urandom_range(0, 9) != 0));
        k = $urandom_range(4, 40);
        repeat (k) plan.push_back(make_tick());
      end else begin
        k = $urandom_range(1, 20);
        repeat (k) plan.push_back(random_item());
      end
      send_items(plan);

      // Long receiver hold-off while items keep coming.
      if (!held && n_sent >= 350) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      // One pause until the block has returned everything.
      if (!paused && n_sent >= 750) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_q);

    $display("Covered %0d loads and %0d ticks; %0d results checked.",
             sb.n_loads, sb.n_ticks, sb.n_checked);
    $display("Saw %0d task switches, %0d refills and %0d no-ready results; %0d mismatches.",
             sb.n_switches, sb.n_refills, sb.n_no_ready, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
